[hw/rtl/bcm_led_dimmer_core_macros.svh]
// ----------------------------------------------------------------------------
// LED dimmer core assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef BCM_LED_DIMMER_CORE_MACROS_SVH
`define BCM_LED_DIMMER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BCM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bcm_led_dimmer_core: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bcm_led_dimmer_core: assertion failed");

`endif

[hw/rtl/bcm_pkg.sv]
// ----------------------------------------------------------------------------
// LED dimmer package
// Opcodes, register indexes, reset values and the tick pattern function.
// ----------------------------------------------------------------------------
`default_nettype none

package bcm_pkg;

    localparam int unsigned DATA_W        = 8;
    localparam int unsigned TARGET_W      = 10;
    localparam int unsigned CFG_ADDR_W    = 1;
    localparam int unsigned BIT_DEPTH_DEF = 5;
    localparam int unsigned NUM_CH        = 8;

    localparam logic [DATA_W-1:0] STEP_SIZE_RST  = 8'd4;
    localparam logic [DATA_W-1:0] MAX_BRIGHT_RST = 8'd255;
    localparam logic [5:0]        CH_FULL        = 6'd63;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_UP   = 2'd1,
        OP_DOWN = 2'd2,
        OP_SET  = 2'd3
    } opcode_t;

    localparam logic [CFG_ADDR_W-1:0] REG_STEP_SIZE  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_BRIGHT = 1'b1;

    // Level of one 6-bit channel; seg selects which quarter of the lamp range it covers.
    function automatic logic [5:0] chan_level(input logic [7:0] lvl, input logic [1:0] seg);
        logic [5:0] res;
        if (lvl[7:6] < seg) begin
            res = 6'd0;
        end else if (lvl[7:6] > seg) begin
            res = CH_FULL;
        end else begin
            res = lvl[5:0];
        end
        return res;
    endfunction

    // Channels 0..3 sit on bits 0..3, mirrored on bits 7..4; channel 3 fills first.
    function automatic logic [NUM_CH-1:0] tick_pattern(input logic [7:0] lvl,
                                                       input logic [2:0] pos);
        logic [NUM_CH-1:0] pat;
        logic [1:0]        ch;
        logic [5:0]        lv;
        pat = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            ch     = (c < 4) ? 2'(c) : 2'(7 - c);
            lv     = chan_level(lvl, 2'(3) - ch);
            pat[c] = |((lv >> pos) & 6'd1);
        end
        return pat;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/bcm_led_dimmer_core.sv]
// ----------------------------------------------------------------------------
// Bit angle modulation LED dimmer core
// Lamp level control and per-weight channel pattern generation.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (s_opcode, s_target_level) arrive on a valid/ready channel.
//   Each word yields exactly one result word (m_pattern, m_next_period,
//   m_level) on a valid/ready channel. A tick returns the pattern for the
//   current bit weight and the timer compare value for the next tick; step
//   up, step down and set return zero pattern and period plus the new level.
//   step_size and max_brightness are written through cfg_we/cfg_addr/cfg_wdata;
//   write them only while the core is idle, as the core does not enforce it.
// Timing:
//   Two register stages (input word, result word): an accepted word moves
//   from the input stage into the result stage and onto m_valid. One word
//   per cycle is sustained while m_ready stays high; the lamp level and bit
//   position update as a word moves into the result stage.
// Reset and stall:
//   Reset clears the level, bit position and both stages and restores the
//   register defaults. While m_ready is low the result holds, the input stage
//   takes one more word, and then s_ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bcm_led_dimmer_core #(
    parameter int unsigned BIT_DEPTH = bcm_pkg::BIT_DEPTH_DEF
) (
    input  wire  logic                                    aclk,
    input  wire  logic                                    aresetn,
    input  wire  logic                                    cfg_we,
    input  wire  logic [bcm_pkg::CFG_ADDR_W-1:0]          cfg_addr,
    input  wire  logic [bcm_pkg::DATA_W-1:0]              cfg_wdata,
    input  wire  logic                                    s_valid,
    output logic                                          s_ready,
    input  wire  bcm_pkg::opcode_t                        s_opcode,
    input  wire  logic signed [bcm_pkg::TARGET_W-1:0]     s_target_level,
    output logic                                          m_valid,
    input  wire  logic                                    m_ready,
    output logic [bcm_pkg::NUM_CH-1:0]                    m_pattern,
    output logic [bcm_pkg::DATA_W-1:0]                    m_next_period,
    output logic [bcm_pkg::DATA_W-1:0]                    m_level
);
    import bcm_pkg::*;

    localparam int unsigned POS_W = $clog2(BIT_DEPTH + 1);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(BIT_DEPTH);

    // Configuration and state
    logic [DATA_W-1:0] step_size_reg;
    logic [DATA_W-1:0] max_bright_reg;
    logic [DATA_W-1:0] lamp_level_reg;
    logic [DATA_W-1:0] lamp_level_next;
    logic [POS_W-1:0]  bit_pos_reg;
    logic [POS_W-1:0]  bit_pos_next;

    // Input stage
    logic                             in_valid_reg;
    opcode_t                          in_op_reg;
    logic signed [TARGET_W-1:0]       in_target_reg;

    // Result stage
    logic                out_valid_reg;
    logic [NUM_CH-1:0]   pattern_reg;
    logic [NUM_CH-1:0]   pattern_next;
    logic [DATA_W-1:0]   period_reg;
    logic [DATA_W-1:0]   period_next;

    logic advance;
    logic fire;

    logic [DATA_W:0]            up_sum;
    logic [DATA_W-1:0]          up_level;
    logic [DATA_W-1:0]          down_level;
    logic [DATA_W-1:0]          set_level;
    logic signed [TARGET_W-1:0] max_ext;

    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    assign m_valid       = out_valid_reg;
    assign m_pattern     = pattern_reg;
    assign m_next_period = period_reg;
    assign m_level       = lamp_level_reg;

    // Level arithmetic
    assign up_sum     = {1'b0, lamp_level_reg} + {1'b0, step_size_reg};
    assign up_level   = (up_sum <= {1'b0, max_bright_reg}) ? up_sum[DATA_W-1:0]
                                                           : max_bright_reg;
    assign down_level = (lamp_level_reg >= step_size_reg) ? (lamp_level_reg - step_size_reg)
                                                          : '0;
    assign max_ext    = signed'({{(TARGET_W-DATA_W){1'b0}}, max_bright_reg});

    always_comb begin
        if (in_target_reg > max_ext) begin
            set_level = max_bright_reg;
        end else if (in_target_reg[TARGET_W-1]) begin
            set_level = '0;
        end else begin
            set_level = in_target_reg[DATA_W-1:0];
        end
    end

    always_comb begin
        lamp_level_next = lamp_level_reg;
        bit_pos_next    = bit_pos_reg;
        pattern_next    = '0;
        period_next     = '0;
        unique case (in_op_reg)
            OP_TICK: begin
                pattern_next = tick_pattern(lamp_level_reg, 3'(bit_pos_reg));
                if (bit_pos_reg == POS_LAST) begin
                    bit_pos_next = '0;
                    period_next  = DATA_W'(2);
                end else begin
                    bit_pos_next = bit_pos_reg + POS_W'(1);
                    period_next  = DATA_W'(1) << bit_pos_reg;
                end
            end
            OP_UP: begin
                lamp_level_next = up_level;
            end
            OP_DOWN: begin
                lamp_level_next = down_level;
            end
            OP_SET: begin
                lamp_level_next = set_level;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg  <= STEP_SIZE_RST;
            max_bright_reg <= MAX_BRIGHT_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_STEP_SIZE:  step_size_reg  <= cfg_wdata;
                REG_MAX_BRIGHT: max_bright_reg <= cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            lamp_level_reg <= '0;
            bit_pos_reg    <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                lamp_level_reg <= lamp_level_next;
                bit_pos_reg    <= bit_pos_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg     <= s_opcode;
            in_target_reg <= s_target_level;
        end
        if (fire) begin
            pattern_reg <= pattern_next;
            period_reg  <= period_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/bcm_checker.sv]
// ----------------------------------------------------------------------------
// LED dimmer port checker
// Port-level properties of the dimmer core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bcm_led_dimmer_core_macros.svh"

module bcm_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [bcm_pkg::NUM_CH-1:0]  m_pattern,
    input wire logic [bcm_pkg::DATA_W-1:0]  m_next_period,
    input wire logic [bcm_pkg::DATA_W-1:0]  m_level
);
    import bcm_pkg::*;

    logic [NUM_CH+2*DATA_W-1:0] m_word;

    assign m_word = {m_pattern, m_next_period, m_level};

    // Stalled input word stays offered
    `BCM_ASSERT_NEXT(a_in_hold, s_valid && !s_ready, s_valid)

    // Stalled result word holds
    `BCM_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_word))

    // Empty result stage always leaves room for a new word
    `BCM_ASSERT_NOW(a_ready_when_empty, !m_valid, s_ready)

    // Tick period is a single weight bit
    `BCM_ASSERT_NOW(a_period_onehot, m_valid, $onehot0(m_next_period))

    // Only ticks drive a pattern: a nonzero pattern must carry a nonzero period
    `BCM_ASSERT_NOW(a_pattern_tick, m_valid && (m_pattern != '0), m_next_period != '0)

endmodule

bind bcm_led_dimmer_core bcm_checker u_bcm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_pattern     (m_pattern),
    .m_next_period (m_next_period),
    .m_level       (m_level)
);

`default_nettype wire
